[rtl/mcfh_pkg.sv]
// Package for the motor current command and feedback hub.
// Holds the codes, limits, frame identifiers and shared types.
// No dependencies; every other file imports it.
package mcfh_pkg;

    // Motor population and widths
    localparam int MOTOR_COUNT = 8;
    localparam int MOTOR_W     = $clog2(MOTOR_COUNT);

    // Current limits per motor type
    localparam logic signed [15:0] LIMIT_SMALL = 16'sd10000;
    localparam logic signed [15:0] LIMIT_LARGE = 16'sd16384;
    localparam logic [1:0] TYPE_SMALL = 2'd1;
    localparam logic [1:0] TYPE_LARGE = 2'd2;

    // Frame identifiers
    localparam logic [10:0] ID_LOW_GROUP  = 11'h200;
    localparam logic [10:0] ID_HIGH_GROUP = 11'h1FF;
    localparam logic [10:0] ID_FB_FIRST   = 11'h201;
    localparam logic [10:0] ID_FB_LAST    = 11'h208;

    // Angle conversion: raw * 360 / 8192
    localparam logic signed [24:0] ANGLE_SCALE = 25'sd360;
    localparam int                 ANGLE_SHIFT = 13;
    localparam logic signed [24:0] ANGLE_BIAS  = 25'sd8191;

    // Configuration
    localparam logic [15:0] SEND_PERIOD_RESET = 16'd50;
    localparam logic        CFG_MOTOR_TYPES   = 1'b0;
    localparam logic        CFG_SEND_PERIOD   = 1'b1;

    // Result kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input command codes
    typedef enum logic [1:0] {
        CMD_SET  = 2'd0,
        CMD_TICK = 2'd1,
        CMD_RX   = 2'd2,
        CMD_READ = 2'd3
    } cmd_t;

    // Classified operation passed from front to back
    typedef struct packed {
        cmd_t               op;
        logic [MOTOR_W-1:0] motor;
        logic               idx_ok;
        logic [15:0]        value;   // setpoint for set, speed for feedback
        logic [11:0]        angle;   // converted angle for feedback
    } op_t;

    // Configuration write
    typedef struct packed {
        logic        we;
        logic        index;
        logic [15:0] data;
    } cfg_wr_t;

endpackage

[rtl/motor_can_current_feedback_hub_core.sv]
// Top level of the motor current command and feedback hub.
// Depends on mcfh_pkg, mcfh_front, mcfh_queue and mcfh_back.
//
//   channel  direction  handshake            contents
//   s_       in         s_tvalid/s_tready    command word, cmd in s_tuser
//   m_       out        m_tvalid/m_tready    frame or read reply, kind in m_tuser
//   cfg_     in         cfg_we               register writes, no read-back
//
// Set, receive and quiet ticks update the back-end state; a read loads the
// output register; a sending tick emits two frames in turn through the single
// output register. A two-entry queue lets the front keep accepting while the
// output is stalled. Reset clears all motor state, the counter and the
// configuration registers (send period back to 50).
module motor_can_current_feedback_hub_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // motor_index, current_setpoint, rx_id, rx_payload, pad
    input  logic [1:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // frame_id, frame_data, angle_deg, speed_rpm, pad
    output logic         m_tlast,
    output logic         m_tuser,   // kind
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_wdata
);
    import mcfh_pkg::*;

    logic    q_full;
    logic    q_push;
    op_t     push_op;
    logic    q_pop;
    logic    q_valid;
    op_t     head_op;
    cfg_wr_t cfg;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_wdata;

    mcfh_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    mcfh_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .q_valid (q_valid),
        .head_op (head_op)
    );

    mcfh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .head_op  (head_op),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/mcfh_front.sv]
// Front end: takes input words, classifies them and converts feedback angles.
// Depends on mcfh_pkg; feeds mcfh_queue.
module mcfh_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output mcfh_pkg::op_t        q_op
);
    import mcfh_pkg::*;

    cmd_t               cmd;
    logic [3:0]         idx;
    logic               idx_ok;
    logic [10:0]        rx_id;
    logic               id_ok;
    logic [10:0]        id_off;
    logic signed [15:0] raw;
    logic signed [24:0] prod;
    logic signed [24:0] biased;
    logic signed [24:0] ang;
    logic               keep;

    // Field unpacking and range checks
    always_comb
    begin
        cmd    = cmd_t'(s_tuser);
        idx    = s_tdata[3:0];
        idx_ok = (idx >= 4'd1) && (idx <= 4'(MOTOR_COUNT));
        rx_id  = s_tdata[30:20];
        id_ok  = (rx_id >= ID_FB_FIRST) && (rx_id <= ID_FB_LAST);
        id_off = rx_id - ID_FB_FIRST;
        raw    = $signed(s_tdata[62:47]);
    end

    // Angle in degrees, truncated toward zero
    always_comb
    begin
        prod   = 25'(raw) * ANGLE_SCALE;
        biased = prod + (prod[24] ? ANGLE_BIAS : 25'sd0);
        ang    = biased >>> ANGLE_SHIFT;
    end

    // Drop sets to bad motors and frames with foreign ids
    always_comb
    begin
        keep = 1'b1;
        if (cmd == CMD_SET && !idx_ok)
            keep = 1'b0;
        if (cmd == CMD_RX && !id_ok)
            keep = 1'b0;

        q_op.op     = cmd;
        q_op.idx_ok = idx_ok;
        q_op.angle  = ang[11:0];
        if (cmd == CMD_RX)
        begin
            q_op.motor = id_off[MOTOR_W-1:0];
            q_op.value = s_tdata[46:31];
        end
        else
        begin
            q_op.motor = MOTOR_W'(idx - 4'd1);
            q_op.value = s_tdata[19:4];
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && keep;

endmodule

[rtl/mcfh_queue.sv]
// Short queue of classified operations between front and back.
// Depends on mcfh_pkg.
module mcfh_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mcfh_pkg::op_t push_op,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output mcfh_pkg::op_t head_op
);
    import mcfh_pkg::*;

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head_op = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

[rtl/mcfh_back.sv]
// Back end: holds motor state and configuration, executes operations and
// drives the output register. Depends on mcfh_pkg; fed by mcfh_queue.
module mcfh_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mcfh_pkg::cfg_wr_t cfg,
    input  logic             q_valid,
    input  mcfh_pkg::op_t    head_op,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [103:0]     m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);
    import mcfh_pkg::*;

    // Symmetric clamp to the limit of a motor type
    function automatic logic [15:0] clamp_current(input logic [15:0] sp, input logic [1:0] code);
        logic signed [15:0] v;
        logic signed [15:0] lim;
        v   = $signed(sp);
        lim = (code == TYPE_SMALL) ? LIMIT_SMALL :
              (code == TYPE_LARGE) ? LIMIT_LARGE : 16'sd0;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v;
    endfunction

    logic [15:0] setpoint_reg [MOTOR_COUNT];
    logic [11:0] angle_reg [MOTOR_COUNT];
    logic [15:0] speed_reg [MOTOR_COUNT];
    logic [15:0] elapsed_reg;
    logic [15:0] elapsed_next;
    logic [15:0] motor_types_reg;
    logic [15:0] send_period_reg;
    logic        pend_reg;
    logic        pend_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_kind_reg;
    logic        out_kind_next;
    logic        out_last_reg;
    logic        out_last_next;
    logic [10:0] out_id_reg;
    logic [10:0] out_id_next;
    logic [63:0] out_data_reg;
    logic [63:0] out_data_next;
    logic [11:0] out_angle_reg;
    logic [11:0] out_angle_next;
    logic [15:0] out_speed_reg;
    logic [15:0] out_speed_next;

    logic        out_free;
    logic [15:0] elapsed_inc;
    logic        send;
    logic [63:0] group_data;
    logic        wr_set;
    logic        wr_fb;

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = q_valid && !pend_reg && out_free;

    // Saturating millisecond count and send decision
    always_comb
    begin
        elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
        send        = elapsed_inc > send_period_reg;
    end

    // Four clamped currents; low group first, high group while pending
    always_comb
    begin
        logic [MOTOR_W-1:0] m;
        group_data = '0;
        for (int k = 0; k < 4; k++)
        begin
            m = MOTOR_W'(k) + (pend_reg ? MOTOR_W'(4) : MOTOR_W'(0));
            group_data[63 - 16 * k -: 16] =
                clamp_current(setpoint_reg[m], motor_types_reg[2 * m +: 2]);
        end
    end

    // Operation execution and output register load
    always_comb
    begin
        elapsed_next   = elapsed_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        out_id_next    = out_id_reg;
        out_data_next  = out_data_reg;
        out_angle_next = out_angle_reg;
        out_speed_next = out_speed_reg;
        wr_set         = 1'b0;
        wr_fb          = 1'b0;

        if (pend_reg && out_free)
        begin
            // second command frame of a send
            pend_next      = 1'b0;
            out_valid_next = 1'b1;
            out_kind_next  = KIND_FRAME;
            out_last_next  = 1'b1;
            out_id_next    = ID_HIGH_GROUP;
            out_data_next  = group_data;
            out_angle_next = '0;
            out_speed_next = '0;
        end
        else if (pop)
        begin
            case (head_op.op)
                CMD_SET:
                    wr_set = 1'b1;
                CMD_RX:
                    wr_fb = 1'b1;
                CMD_TICK:
                begin
                    elapsed_next = elapsed_inc;
                    if (send)
                    begin
                        elapsed_next   = '0;
                        pend_next      = 1'b1;
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_FRAME;
                        out_last_next  = 1'b0;
                        out_id_next    = ID_LOW_GROUP;
                        out_data_next  = group_data;
                        out_angle_next = '0;
                        out_speed_next = '0;
                    end
                end
                CMD_READ:
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_READ;
                    out_last_next  = 1'b1;
                    out_id_next    = '0;
                    out_data_next  = '0;
                    out_angle_next = head_op.idx_ok ? angle_reg[head_op.motor] : '0;
                    out_speed_next = head_op.idx_ok ? speed_reg[head_op.motor] : '0;
                end
                default:
                    ;
            endcase
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg     <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            motor_types_reg <= '0;
            send_period_reg <= SEND_PERIOD_RESET;
        end
        else
        begin
            elapsed_reg   <= elapsed_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg.we)
            begin
                case (cfg.index)
                    CFG_MOTOR_TYPES: motor_types_reg <= cfg.data;
                    CFG_SEND_PERIOD: send_period_reg <= cfg.data;
                    default:         ;
                endcase
            end
        end
    end

    // Per-motor stores, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                setpoint_reg[i] <= '0;
                angle_reg[i]    <= '0;
                speed_reg[i]    <= '0;
            end
        end
        else
        begin
            if (wr_set)
                setpoint_reg[head_op.motor] <= head_op.value;
            if (wr_fb)
            begin
                angle_reg[head_op.motor] <= head_op.angle;
                speed_reg[head_op.motor] <= head_op.value;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_last_reg  <= out_last_next;
        out_id_reg    <= out_id_next;
        out_data_reg  <= out_data_next;
        out_angle_reg <= out_angle_next;
        out_speed_reg <= out_speed_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {1'b0, out_speed_reg, out_angle_reg, out_data_reg, out_id_reg};

endmodule
